[src/assert_macros.svh]
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, quiet while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/pnfc_pkg.sv]
package pnfc_pkg;

  // Item widths
  localparam int unsigned CH_W      = 8;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  // Characters the parser looks for
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OK      = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NOTNORM = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD     = 2'd2;

  // Result of one parser step
  typedef struct packed {
    logic                 emit;
    logic [VERDICT_W-1:0] verdict;
  } pnfc_result_t;

  // ASCII A-Z or a-z
  function automatic logic is_drive_letter(input logic [CH_W-1:0] c);
    is_drive_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

[src/pnfc_parser.sv]
module pnfc_parser
  import pnfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [CH_W-1:0] ch,
  output pnfc_result_t    result
);

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_NORMAL  = 3'd1,
    ST_FIRSTSEP = 3'd2,
    ST_SEP     = 3'd3,
    ST_CUR     = 3'd4,
    ST_PAR     = 3'd5,
    ST_DRIVE   = 3'd6
  } state_t;

  state_t state_r, state_nxt;
  logic   swallow_r, swallow_nxt;
  logic   early;
  logic [VERDICT_W-1:0] early_verdict;
  state_t walk;

  // Walk one byte through the parser
  always_comb begin
    state_nxt     = state_r;
    swallow_nxt   = swallow_r;
    result.emit   = 1'b0;
    result.verdict = VERDICT_OK;
    early         = 1'b0;
    early_verdict = VERDICT_OK;
    walk          = state_r;

    if (swallow_r) begin
      // drop bytes until the terminator re-arms
      if (ch == CH_NUL) begin
        swallow_nxt = 1'b0;
        state_nxt   = ST_START;
      end
    end else if (ch == CH_NUL) begin
      result.emit = 1'b1;
      unique case (state_r)
        ST_NORMAL, ST_FIRSTSEP:    result.verdict = VERDICT_OK;
        ST_SEP, ST_CUR, ST_PAR:    result.verdict = VERDICT_NOTNORM;
        default:                   result.verdict = VERDICT_BAD;
      endcase
      state_nxt = ST_START;
    end else begin
      unique case (state_r)
        ST_NORMAL: begin
          if (ch == CH_SLASH) walk = ST_SEP;
        end
        ST_FIRSTSEP, ST_SEP: begin
          if (ch == CH_SLASH) begin
            early = 1'b1; early_verdict = VERDICT_NOTNORM;
          end else if (ch == CH_DOT) begin
            walk = ST_CUR;
          end else begin
            walk = ST_NORMAL;
          end
        end
        ST_CUR: begin
          if (ch == CH_SLASH) begin
            early = 1'b1; early_verdict = VERDICT_NOTNORM;
          end else if (ch == CH_DOT) begin
            walk = ST_PAR;
          end else begin
            walk = ST_NORMAL;
          end
        end
        ST_PAR: begin
          if (ch == CH_SLASH) begin
            early = 1'b1; early_verdict = VERDICT_NOTNORM;
          end else begin
            walk = ST_NORMAL;
          end
        end
        ST_DRIVE: begin
          early = 1'b1;
          early_verdict = (ch == CH_COLON) ? VERDICT_OK : VERDICT_BAD;
        end
        default: begin
          // start, and the unused code treated as start
          if (is_drive_letter(ch)) begin
            walk = ST_DRIVE;
          end else if (ch == CH_SLASH) begin
            walk = ST_FIRSTSEP;
          end else begin
            early = 1'b1; early_verdict = VERDICT_BAD;
          end
        end
      endcase

      if (early) begin
        result.emit    = 1'b1;
        result.verdict = early_verdict;
        swallow_nxt    = 1'b1;
        state_nxt      = ST_START;
      end else begin
        state_nxt = walk;
      end
    end

    // only a real step produces a result
    result.emit = result.emit & step;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_START;
      swallow_r <= 1'b0;
    end else if (step) begin
      state_r   <= state_nxt;
      swallow_r <= swallow_nxt;
    end
  end

endmodule

[src/path_normal_form_checker_core.sv]
// Path normal-form checker. Path bytes enter one per item on in_tdata, a zero
// byte ending the path. One verdict item (0 normalized, 1 not normalized,
// 2 invalid format) leaves per path on out_tdata, as soon as it is known: at
// the terminator, or early at a doubled slash, a "." or ".." component, the
// byte after a drive letter, or a bad first byte. Bytes after an early verdict
// give no item until the zero byte re-arms the parser. One byte is taken
// every cycle while the result is not stalled; a byte passes an input
// register and then the parser step into the result register, where its
// verdict is offered. A stalled result stops the parser step; the input
// register then takes at most one more byte and holds it.
module path_normal_form_checker_core
  import pnfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CH_W-1:0]        in_tdata,   // [7:0] ch
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] verdict, [7:2] zero
);

  logic                 in_valid_r;
  logic [CH_W-1:0]      ch_r;
  logic                 out_valid_r;
  logic [VERDICT_W-1:0] verdict_r;
  logic                 advance;
  pnfc_result_t         result;

  // Pipe moves whenever the result register is free or being taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  pnfc_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_valid_r && advance),
    .ch     (ch_r),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r <= in_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      verdict_r <= result.verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-VERDICT_W){1'b0}}, verdict_r};

endmodule

[src/pnfc_checker.sv]
`include "assert_macros.svh"

module pnfc_checker
  import pnfc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result item holds its value
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")

  // verdict is one of the three codes and the pad bits are zero
  `ASSERT_CLK(a_verdict_legal, clk, rst_n, out_tvalid |-> (((out_tdata[VERDICT_W-1:0] == VERDICT_OK) || (out_tdata[VERDICT_W-1:0] == VERDICT_NOTNORM) || (out_tdata[VERDICT_W-1:0] == VERDICT_BAD)) && (out_tdata[OUT_TDATA_W-1:VERDICT_W] == '0)), "illegal verdict")

  // an empty result register never blocks the input
  `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with no result pending")

  // reset empties the result register
  `ASSERT_CLK_NR(a_reset_clears, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind path_normal_form_checker_core pnfc_checker u_pnfc_checker (.*);

[verif/path_normal_form_checker_core_tb.sv]
module path_normal_form_checker_core_tb
  import pnfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Parser states, mirrored from the block's behavior
  typedef enum logic [2:0] {
    PS_START, PS_NORMAL, PS_FIRST_SEP, PS_SEP, PS_CUR_DIR, PS_PAR_DIR, PS_DRIVE
  } parse_st_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [CH_W-1:0]        in_tdata = '0;   // [7:0] ch
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [1:0] verdict, [7:2] zero

  // Predictor state and the verdicts still owed by the block
  parse_st_t            pstate = PS_START;
  bit                   swallow = 1'b0;
  logic [VERDICT_W-1:0] verdict_q[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          in_idle_en = 1'b1;
  bit          out_stall_en = 1'b1;

  path_normal_form_checker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_ascii_alpha(input logic [CH_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Advance the predicted parser by one byte and queue any verdict it gives
  function automatic void predict_verdict(input logic [CH_W-1:0] c);
    bit                   early;
    logic [VERDICT_W-1:0] v;
    early = 1'b0;
    v = VERDICT_OK;
    if (swallow) begin
      if (c == CH_NUL) begin
        swallow = 1'b0;
        pstate = PS_START;
      end
      return;
    end
    // Terminator: verdict follows from where the path stopped
    if (c == CH_NUL) begin
      case (pstate)
        PS_START, PS_DRIVE:     v = VERDICT_BAD;
        PS_NORMAL, PS_FIRST_SEP: v = VERDICT_OK;
        default:                v = VERDICT_NOTNORM;
      endcase
      pstate = PS_START;
      verdict_q.push_back(v);
      return;
    end
    case (pstate)
      PS_START: begin
        if (is_ascii_alpha(c)) pstate = PS_DRIVE;
        else if (c == CH_SLASH) pstate = PS_FIRST_SEP;
        else begin early = 1'b1; v = VERDICT_BAD; end
      end
      PS_NORMAL: begin
        if (c == CH_SLASH) pstate = PS_SEP;
      end
      PS_FIRST_SEP, PS_SEP: begin
        if (c == CH_SLASH) begin early = 1'b1; v = VERDICT_NOTNORM; end
        else if (c == CH_DOT) pstate = PS_CUR_DIR;
        else pstate = PS_NORMAL;
      end
      PS_CUR_DIR: begin
        if (c == CH_SLASH) begin early = 1'b1; v = VERDICT_NOTNORM; end
        else if (c == CH_DOT) pstate = PS_PAR_DIR;
        else pstate = PS_NORMAL;
      end
      PS_PAR_DIR: begin
        if (c == CH_SLASH) begin early = 1'b1; v = VERDICT_NOTNORM; end
        else pstate = PS_NORMAL;
      end
      default: begin
        early = 1'b1;
        v = (c == CH_COLON) ? VERDICT_OK : VERDICT_BAD;
      end
    endcase
    if (early) begin
      swallow = 1'b1;
      pstate = PS_START;
      verdict_q.push_back(v);
    end
  endfunction

  // Compare one result item with the oldest predicted verdict
  function automatic void check_verdict(input logic [OUT_TDATA_W-1:0] d);
    logic [VERDICT_W-1:0] want;
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected verdict, expected none, actual %0d", $time, d[VERDICT_W-1:0]);
      return;
    end
    want = verdict_q.pop_front();
    if (d[VERDICT_W-1:0] !== want) begin
      errors++;
      $display("%0t: verdict mismatch, expected %0d, actual %0d",
               $time, want, d[VERDICT_W-1:0]);
    end
    if (d[OUT_TDATA_W-1:VERDICT_W] !== '0) begin
      errors++;
      $display("%0t: pad bits mismatch, expected 0, actual %h",
               $time, d[OUT_TDATA_W-1:VERDICT_W]);
    end
  endfunction

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_verdict(out_tdata);
      if (in_tvalid && in_tready) predict_verdict(in_tdata);
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!out_stall_en) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Send one item; entered and left at a falling edge
  task automatic send_ch(input logic [CH_W-1:0] c);
    int unsigned gap;
    gap = in_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted verdict has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (verdict_q.size() != 0);
  endtask

  function automatic logic [CH_W-1:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return CH_W'($urandom_range(8'h41, 8'h5A));
    return CH_W'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [CH_W-1:0] rand_name_byte();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(1, 255)); while (c == CH_SLASH);
    return c;
  endfunction

  // Build one path, mostly well formed, and send it with its terminator
  task automatic send_random_path();
    logic [CH_W-1:0] path[$];
    int unsigned     kind;
    int unsigned     ncomp;
    int unsigned     len;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise: any bytes, stray zeros included
      len = $urandom_range(1, 12);
      repeat (len) path.push_back(CH_W'($urandom_range(0, 255)));
    end else begin
      if (kind < 72) begin
        path.push_back(CH_SLASH);
      end else if (kind < 88) begin
        path.push_back(rand_letter());
        if ($urandom_range(0, 3) != 0) path.push_back(CH_COLON);
      end else begin
        path.push_back(CH_W'($urandom_range(1, 255)));
      end
      ncomp = $urandom_range(0, 5);
      for (int i = 0; i < ncomp; i++) begin
        if (i > 0) path.push_back(CH_SLASH);
        case ($urandom_range(0, 9))
          6: path.push_back(CH_DOT);
          7: begin path.push_back(CH_DOT); path.push_back(CH_DOT); end
          8: ;  // empty component doubles the slash
          9: repeat (3) path.push_back(CH_DOT);
          default: begin
            len = $urandom_range(1, 6);
            repeat (len) path.push_back(rand_name_byte());
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0) path.push_back(CH_SLASH);
    end
    path.push_back(CH_NUL);
    foreach (path[i]) send_ch(path[i]);
  endtask

  // Empty path, each terminator class and each early verdict
  task automatic test_directed();
    send_ch(CH_NUL);
    send_ch(CH_SLASH); send_ch(CH_NUL);
    send_ch(8'h43); send_ch(CH_COLON); send_ch(8'hFF); send_ch(CH_NUL);
    send_ch(8'h7A); send_ch(CH_NUL);
    send_ch(8'h40); send_ch(CH_NUL);
    send_ch(CH_SLASH); send_ch(CH_SLASH); send_ch(CH_NUL);
    send_ch(CH_SLASH); send_ch(CH_DOT); send_ch(CH_NUL);
    send_ch(CH_SLASH); send_ch(CH_DOT); send_ch(CH_DOT); send_ch(CH_SLASH); send_ch(CH_NUL);
    send_ch(CH_SLASH); send_ch(8'h80); send_ch(CH_SLASH); send_ch(CH_NUL);
  endtask

  task automatic test_random_paths(input int unsigned upto);
    while (items_sent < upto) send_random_path();
  endtask

  // Pause the sender until the block has emptied, then resume
  task automatic test_hold_off();
    repeat (4) send_random_path();
    wait_drained();
    repeat (4) send_random_path();
  endtask

  // Stretches with idling switched off on one side or both
  task automatic test_back_to_back();
    in_idle_en = 1'b0;
    out_stall_en = 1'b0;
    test_random_paths(items_sent + 150);
    in_idle_en = 1'b1;
    test_random_paths(items_sent + 100);
    in_idle_en = 1'b0;
    out_stall_en = 1'b1;
    test_random_paths(items_sent + 100);
    in_idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_paths(700);
    test_hold_off();
    test_back_to_back();
    test_random_paths(1750);

    // Let the tail drain, then watch for stray results
    wait_drained();
    out_stall_en = 1'b0;
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pnfc_pkg.sv
src/pnfc_parser.sv
src/path_normal_form_checker_core.sv
src/pnfc_checker.sv
verif/path_normal_form_checker_core_tb.sv
